// File: sv/rrsr_pkg.sv
// Shared types, constants and helpers for the request/reply slot ring.
// Used by every module of the block but rrsr_ram, and by its checker; depends on nothing.
package rrsr_pkg;

  localparam int SLOTS  = 16;
  localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int FUNC_W = 3;
  localparam int SLOT_W = 4;
  localparam int OCC_W  = 5;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OCC_W-1:0]  occ_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 3'd0,
    FN_READY   = 3'd1,
    FN_TAKE    = 3'd2,
    FN_REPLIED = 3'd3,
    FN_POLL    = 3'd4,
    FN_DONE    = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_UNHANDLED = 2'd1,
    ST_REPLIED   = 2'd2,
    ST_DONE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RC_OK    = 2'd0,
    RC_FULL  = 2'd1,
    RC_NONE  = 2'd2,
    RC_STATE = 2'd3
  } rc_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    slot_t             slot_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0] result_code;
    slot_t      granted_slot;
    logic       reply_present;
    occ_t       occupancy;
    occ_t       freed_count;
  } res_t;

  typedef struct packed {
    logic    rd_en;
    ptr_t    rd_addr;
    logic    wr_en;
    ptr_t    wr_addr;
    status_t wr_data;
  } st_req_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == ptr_t'(SLOTS - 1)) ? ptr_t'(0) : ptr_t'(p + ptr_t'(1));
  endfunction

endpackage

// File: sv/rrsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module rrsr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/rrsr_store.sv
// Slot status store: RAM plus per-slot valid bits so unwritten slots read empty.
// Depends on rrsr_pkg and rrsr_ram.
module rrsr_store (
  input  logic               clk,
  input  logic               rst_n,
  input  rrsr_pkg::st_req_t  st_req,
  output rrsr_pkg::status_t  rd_status
);

  logic [rrsr_pkg::SLOTS-1:0] valid_r;
  logic                       rd_vld_r;
  logic [1:0]                 ram_q;

  rrsr_ram #(
    .WIDTH (2),
    .DEPTH (rrsr_pkg::SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (st_req.wr_en),
    .wr_addr (st_req.wr_addr),
    .wr_data (st_req.wr_data),
    .rd_en   (st_req.rd_en),
    .rd_addr (st_req.rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (st_req.wr_en) begin
        valid_r[st_req.wr_addr] <= 1'b1;
      end
      if (st_req.rd_en) begin
        rd_vld_r <= valid_r[st_req.rd_addr];
      end
    end
  end

  assign rd_status = rd_vld_r ? rrsr_pkg::status_t'(ram_q) : rrsr_pkg::ST_EMPTY;

endmodule

// File: sv/rrsr_ctrl.sv
// Sequencer for the slot ring: pointers, occupancy, status checks, reclaim walk
// and the result register. Depends on rrsr_pkg; drives the status store.
module rrsr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrsr_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrsr_pkg::res_t     out_data,
  output rrsr_pkg::st_req_t  st_req,
  input  rrsr_pkg::status_t  rd_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WALK_RD,
    S_WALK,
    S_HOLD
  } state_t;

  state_t             state_r, state_nxt;
  rrsr_pkg::in_req_t  req_r, req_nxt;
  rrsr_pkg::ptr_t     alloc_ptr_r, alloc_ptr_nxt;
  rrsr_pkg::ptr_t     take_ptr_r, take_ptr_nxt;
  rrsr_pkg::ptr_t     reclaim_ptr_r, reclaim_ptr_nxt;
  rrsr_pkg::cnt_t     used_r, used_nxt;
  rrsr_pkg::cnt_t     freed_r, freed_nxt;
  rrsr_pkg::res_t     res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  rrsr_pkg::res_t     out_data_r, out_data_nxt;
  logic               idx_ok;
  logic               full;
  rrsr_pkg::ptr_t     idx_ptr;
  rrsr_pkg::ptr_t     in_ptr;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx_ok  = 32'(req_r.slot_index) < 32'(rrsr_pkg::SLOTS);
  assign full    = used_r >= rrsr_pkg::cnt_t'(rrsr_pkg::SLOTS);
  assign idx_ptr = rrsr_pkg::ptr_t'(req_r.slot_index);
  assign in_ptr  = rrsr_pkg::ptr_t'(in_data.slot_index);

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    alloc_ptr_nxt   = alloc_ptr_r;
    take_ptr_nxt    = take_ptr_r;
    reclaim_ptr_nxt = reclaim_ptr_r;
    used_nxt        = used_r;
    freed_nxt       = freed_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    st_req          = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          freed_nxt    = '0;
          st_req.rd_en = 1'b1;
          priority if (in_data.func == rrsr_pkg::FN_ALLOC) begin
            st_req.rd_addr = alloc_ptr_r;
          end else if (in_data.func == rrsr_pkg::FN_TAKE) begin
            st_req.rd_addr = take_ptr_r;
          end else begin
            st_req.rd_addr = in_ptr;
          end
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        res_nxt.result_code   = rrsr_pkg::RC_OK;
        res_nxt.granted_slot  = '0;
        res_nxt.reply_present = 1'b0;
        res_nxt.freed_count   = '0;
        state_nxt             = S_HOLD;
        unique case (req_r.func)
          rrsr_pkg::FN_ALLOC: begin
            if (full) begin
              res_nxt.result_code = rrsr_pkg::RC_FULL;
            end else if (rd_status != rrsr_pkg::ST_EMPTY) begin
              res_nxt.result_code = rrsr_pkg::RC_STATE;
            end else begin
              res_nxt.granted_slot = rrsr_pkg::slot_t'(alloc_ptr_r);
              alloc_ptr_nxt        = rrsr_pkg::ring_next(alloc_ptr_r);
              used_nxt             = used_r + rrsr_pkg::cnt_t'(1);
            end
          end
          rrsr_pkg::FN_READY: begin
            if (!idx_ok || rd_status != rrsr_pkg::ST_EMPTY) begin
              res_nxt.result_code = rrsr_pkg::RC_STATE;
            end else begin
              st_req.wr_en   = 1'b1;
              st_req.wr_addr = idx_ptr;
              st_req.wr_data = rrsr_pkg::ST_UNHANDLED;
            end
          end
          rrsr_pkg::FN_TAKE: begin
            if (rd_status == rrsr_pkg::ST_UNHANDLED) begin
              res_nxt.granted_slot = rrsr_pkg::slot_t'(take_ptr_r);
              take_ptr_nxt         = rrsr_pkg::ring_next(take_ptr_r);
            end else if (rd_status == rrsr_pkg::ST_EMPTY) begin
              res_nxt.result_code = rrsr_pkg::RC_NONE;
            end else begin
              res_nxt.result_code = rrsr_pkg::RC_STATE;
            end
          end
          rrsr_pkg::FN_REPLIED: begin
            if (!idx_ok || rd_status != rrsr_pkg::ST_UNHANDLED) begin
              res_nxt.result_code = rrsr_pkg::RC_STATE;
            end else begin
              st_req.wr_en   = 1'b1;
              st_req.wr_addr = idx_ptr;
              st_req.wr_data = rrsr_pkg::ST_REPLIED;
            end
          end
          rrsr_pkg::FN_POLL: begin
            if (!idx_ok) begin
              res_nxt.result_code = rrsr_pkg::RC_STATE;
            end else begin
              res_nxt.reply_present = (rd_status == rrsr_pkg::ST_REPLIED);
            end
          end
          rrsr_pkg::FN_DONE: begin
            if (!idx_ok || rd_status != rrsr_pkg::ST_REPLIED) begin
              res_nxt.result_code = rrsr_pkg::RC_STATE;
            end else begin
              st_req.wr_en   = 1'b1;
              st_req.wr_addr = idx_ptr;
              st_req.wr_data = rrsr_pkg::ST_DONE;
              state_nxt      = S_WALK_RD;
            end
          end
          default: begin
            res_nxt.result_code = rrsr_pkg::RC_STATE;
          end
        endcase
        res_nxt.occupancy = rrsr_pkg::occ_t'(used_nxt);
      end

      S_WALK_RD: begin
        st_req.rd_en   = 1'b1;
        st_req.rd_addr = reclaim_ptr_r;
        state_nxt      = S_WALK;
      end

      S_WALK: begin
        if (used_r != '0 && rd_status == rrsr_pkg::ST_DONE) begin
          st_req.wr_en    = 1'b1;
          st_req.wr_addr  = reclaim_ptr_r;
          st_req.wr_data  = rrsr_pkg::ST_EMPTY;
          reclaim_ptr_nxt = rrsr_pkg::ring_next(reclaim_ptr_r);
          st_req.rd_en    = 1'b1;
          st_req.rd_addr  = rrsr_pkg::ring_next(reclaim_ptr_r);
          used_nxt        = used_r - rrsr_pkg::cnt_t'(1);
          freed_nxt       = freed_r + rrsr_pkg::cnt_t'(1);
        end else begin
          res_nxt.occupancy   = rrsr_pkg::occ_t'(used_r);
          res_nxt.freed_count = rrsr_pkg::occ_t'(freed_r);
          state_nxt           = S_HOLD;
        end
      end

      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      alloc_ptr_r   <= '0;
      take_ptr_r    <= '0;
      reclaim_ptr_r <= '0;
      used_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      alloc_ptr_r   <= alloc_ptr_nxt;
      take_ptr_r    <= take_ptr_nxt;
      reclaim_ptr_r <= reclaim_ptr_nxt;
      used_r        <= used_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    freed_r    <= freed_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: sv/request_reply_slot_ring_top.sv
// Top level of the request/reply slot ring: sequencer plus slot status store.
// Depends on rrsr_pkg, rrsr_ctrl, rrsr_store (and rrsr_ram below it).
//
// A ring of SLOTS request slots driven by one operation per request (allocate,
// mark ready, take, mark replied, poll, mark done), one result per request.
// Slot status lives in a small RAM with one read and one write port. Every
// operation reads one status, checks it in the sequencer and writes back at
// most one entry; a mark done that succeeds then runs the reclaim walk, which
// reads and frees one slot per cycle through the same RAM ports. Every request
// is accepted and read, then checked, then its result is loaded into the result
// register. A new request is accepted only while the sequencer is idle; a
// finished result waiting in the output register does not block acceptance.
// Slot status resets to empty through per-slot valid bits, so no clearing
// pass is needed.
module request_reply_slot_ring_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrsr_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrsr_pkg::res_t     out_data
);

  rrsr_pkg::st_req_t st_req;
  rrsr_pkg::status_t rd_status;

  rrsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .st_req    (st_req),
    .rd_status (rd_status)
  );

  rrsr_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_req    (st_req),
    .rd_status (rd_status)
  );

endmodule

// File: sv/rrsr_checker.sv
// Port-level assertions for the slot ring, bound to the top level.
// Depends on rrsr_pkg and request_reply_slot_ring_top.
module rrsr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input rrsr_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input rrsr_pkg::res_t     out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_code == rrsr_pkg::RC_FULL |->
      out_data.occupancy == rrsr_pkg::occ_t'(rrsr_pkg::SLOTS))
    else $error("full reported below capacity");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_code != rrsr_pkg::RC_OK |->
      out_data.granted_slot == '0 && out_data.freed_count == '0 && !out_data.reply_present)
    else $error("failed request carries a grant, reclaim or reply");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.occupancy <= rrsr_pkg::occ_t'(rrsr_pkg::SLOTS) &&
      out_data.freed_count <= rrsr_pkg::occ_t'(rrsr_pkg::SLOTS))
    else $error("occupancy or reclaim count out of range");

endmodule

bind request_reply_slot_ring_top rrsr_checker u_rrsr_checker (.*);
